/* design/tbas_pkg.sv */
// ----------------------------------------------------------------------------
// tbas_pkg - shared types and codes for the trip boundary angle search
// Event, status and result codes, the register set, the sequencer state and
// the result word layout.
// ----------------------------------------------------------------------------
package tbas_pkg;

  // request kinds on the input stream (tuser)
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_STOP   = 2'd1;
  localparam logic [1:0] REQ_STATUS = 2'd2;

  // instrument status signatures
  localparam logic [6:0] CODE_NOT_TRIPPED = 7'd3;
  localparam logic [6:0] CODE_TRIPPED     = 7'd4;
  localparam logic [6:0] CODE_SEQ_END     = 7'd5;

  // result kinds on the output stream (tuser)
  localparam logic [1:0] KIND_PROBE    = 2'd0;
  localparam logic [1:0] KIND_BOUNDARY = 2'd1;
  localparam logic [1:0] KIND_FINISHED = 2'd2;
  localparam logic [1:0] KIND_STOPPED  = 2'd3;

  // search stage
  localparam logic [1:0] STAGE_PROBE0   = 2'd1;
  localparam logic [1:0] STAGE_PROBE180 = 2'd2;
  localparam logic [1:0] STAGE_BISECT   = 2'd3;

  // last seen trip outcome
  localparam logic [1:0] OUTC_NONE        = 2'd0;
  localparam logic [1:0] OUTC_NOT_TRIPPED = 2'd1;
  localparam logic [1:0] OUTC_TRIPPED     = 2'd2;

  // register indexes
  localparam logic [1:0] REG_IR_FIRST  = 2'd0;
  localparam logic [1:0] REG_IR_LAST   = 2'd1;
  localparam logic [1:0] REG_IR_INCR   = 2'd2;
  localparam logic [1:0] REG_ANGLE_TOL = 2'd3;

  // 180 degrees in 1/256 degree
  localparam logic [15:0] ANGLE_180 = 16'd46080;

  typedef struct packed {
    logic [15:0] ir_first;
    logic [15:0] ir_last;
    logic [15:0] ir_increment;
    logic [15:0] angle_tolerance;
  } cfg_t;

  typedef struct packed {
    logic        running;
    logic [1:0]  stage;
    logic [1:0]  outcome;
    logic        first_tripped;
    logic [15:0] start_angle;
    logic [15:0] end_angle;
    logic [15:0] probe_angle;
    logic [15:0] ir_now;
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] angle;
    logic [15:0] ir_value;
    logic        last;
  } result_t;

endpackage

/* design/tbas_step.sv */
// ----------------------------------------------------------------------------
// tbas_step - next-state and result logic of the angle search sequencer
// Given the current state, the registers and one event, produces the next
// state and zero, one or two result words.
// ----------------------------------------------------------------------------
module tbas_step (
  input  tbas_pkg::state_t  st,
  input  tbas_pkg::cfg_t    cfg,
  input  logic [1:0]        req_type,
  input  logic [6:0]        status_code,
  output tbas_pkg::state_t  st_next,
  output logic [1:0]        n_res,
  output tbas_pkg::result_t res0,
  output tbas_pkg::result_t res1
);
  import tbas_pkg::*;

  logic        tripped;
  logic [16:0] mid_sum;
  logic [16:0] ir_sum;
  logic [15:0] ir_sat;
  logic        adv_go;
  logic [15:0] new_start;
  logic [15:0] new_end;
  logic [16:0] mid2_sum;
  logic [15:0] ang_diff;
  result_t     adv_res;

  always_comb begin
    tripped   = (st.outcome == OUTC_TRIPPED);
    mid_sum   = {1'b0, st.start_angle} + {1'b0, st.end_angle};
    ir_sum    = {1'b0, st.ir_now} + {1'b0, cfg.ir_increment};
    ir_sat    = ir_sum[16] ? 16'hFFFF : ir_sum[15:0];
    adv_go    = (st.ir_now < cfg.ir_last);
    new_start = tripped ? st.start_angle : st.probe_angle;
    new_end   = tripped ? st.probe_angle : st.end_angle;
    mid2_sum  = {1'b0, new_start} + {1'b0, new_end};
    ang_diff  = (st.start_angle >= st.end_angle) ? (st.start_angle - st.end_angle)
                                                 : (st.end_angle - st.start_angle);

    // next current step, or finish
    adv_res.kind     = adv_go ? KIND_PROBE : KIND_FINISHED;
    adv_res.angle    = '0;
    adv_res.ir_value = adv_go ? ir_sat : st.ir_now;
    adv_res.last     = 1'b1;

    st_next = st;
    n_res   = 2'd0;
    res0    = '0;
    res1    = '0;

    unique case (req_type)
      REQ_START: begin
        if (!st.running) begin
          st_next.running       = 1'b1;
          st_next.ir_now        = cfg.ir_first;
          st_next.first_tripped = 1'b0;
          st_next.start_angle   = '0;
          st_next.end_angle     = ANGLE_180;
          st_next.probe_angle   = '0;
          st_next.stage         = STAGE_PROBE0;
          res0.kind     = KIND_PROBE;
          res0.angle    = '0;
          res0.ir_value = cfg.ir_first;
          res0.last     = 1'b1;
          n_res         = 2'd1;
        end
      end
      REQ_STOP: begin
        if (st.running) begin
          st_next.running = 1'b0;
          res0.kind     = KIND_STOPPED;
          res0.angle    = '0;
          res0.ir_value = st.ir_now;
          res0.last     = 1'b1;
          n_res         = 2'd1;
        end
      end
      REQ_STATUS: begin
        if (st.running) begin
          if (status_code == CODE_NOT_TRIPPED) begin
            st_next.outcome = OUTC_NOT_TRIPPED;
          end else if (status_code == CODE_TRIPPED) begin
            st_next.outcome = OUTC_TRIPPED;
          end else if (status_code == CODE_SEQ_END && st.outcome != OUTC_NONE) begin
            unique case (st.stage)
              STAGE_PROBE0: begin
                st_next.stage         = STAGE_PROBE180;
                st_next.first_tripped = tripped;
                res0.kind     = KIND_PROBE;
                res0.angle    = st.end_angle;
                res0.ir_value = st.ir_now;
                res0.last     = 1'b1;
                n_res         = 2'd1;
              end
              STAGE_PROBE180: begin
                if (!tripped && !st.first_tripped) begin
                  // no trip at either end: move on
                  res0  = adv_res;
                  n_res = 2'd1;
                  if (adv_go) begin
                    st_next.ir_now        = ir_sat;
                    st_next.first_tripped = 1'b0;
                    st_next.start_angle   = '0;
                    st_next.end_angle     = ANGLE_180;
                    st_next.probe_angle   = '0;
                    st_next.stage         = STAGE_PROBE0;
                  end else begin
                    st_next.running = 1'b0;
                  end
                end else begin
                  st_next.stage       = STAGE_BISECT;
                  st_next.probe_angle = mid_sum[16:1];
                  if (!tripped) begin
                    // search runs from 180 down toward 0
                    st_next.end_angle   = '0;
                    st_next.start_angle = ANGLE_180;
                  end
                  res0.kind     = KIND_PROBE;
                  res0.angle    = mid_sum[16:1];
                  res0.ir_value = st.ir_now;
                  res0.last     = 1'b1;
                  n_res         = 2'd1;
                end
              end
              STAGE_BISECT: begin
                if (ang_diff <= cfg.angle_tolerance) begin
                  res0.kind     = KIND_BOUNDARY;
                  res0.angle    = st.probe_angle;
                  res0.ir_value = st.ir_now;
                  res0.last     = 1'b0;
                  res1          = adv_res;
                  n_res         = 2'd2;
                  if (adv_go) begin
                    st_next.ir_now        = ir_sat;
                    st_next.first_tripped = 1'b0;
                    st_next.start_angle   = '0;
                    st_next.end_angle     = ANGLE_180;
                    st_next.probe_angle   = '0;
                    st_next.stage         = STAGE_PROBE0;
                  end else begin
                    st_next.running = 1'b0;
                  end
                end else begin
                  st_next.start_angle = new_start;
                  st_next.end_angle   = new_end;
                  st_next.probe_angle = mid2_sum[16:1];
                  res0.kind     = KIND_PROBE;
                  res0.angle    = mid2_sum[16:1];
                  res0.ir_value = st.ir_now;
                  res0.last     = 1'b1;
                  n_res         = 2'd1;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/trip_boundary_angle_search_core.sv */
// ----------------------------------------------------------------------------
// trip_boundary_angle_search_core - relay trip boundary search sequencer
// Bisects the phase angle per restraint-current step and streams probe,
// boundary, finish and stop words.
// ----------------------------------------------------------------------------
//
// channel   dir  handshake         payload
// s_*       in   s_tvalid/tready   tuser=req_type, tdata=status_code
// m_*       out  m_tvalid/tready   tuser=out_kind, tdata=angle|ir_value, tlast=last
// cfg_*     in   cfg_valid/ready   cfg_index, cfg_data (always ready)
//
// Cycles: an event is decoded in the cycle it is accepted; its result
// words, if any, are in the output queue on the next cycle. One event per
// cycle sustained while the output side takes one word per cycle and no event
// yields two words. The three-entry output queue sets the figure: s_tready is
// high while at most one word is queued. Reset: synchronous, rst high; registers
// return to their defaults, the queue empties. Stalls on m_tready hold the queue.
module trip_boundary_angle_search_core (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [6:0] status_code, [7] zero
  input  logic [1:0]  s_tuser,    // [1:0] req_type
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [15:0] angle, [31:16] ir_value
  output logic [1:0]  m_tuser,    // [1:0] out_kind
  output logic        m_tlast,    // last
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tbas_pkg::*;

  localparam int QDEPTH = 3;

  cfg_t      cfg;
  state_t    st;
  state_t    st_next;
  logic [1:0] n_res;
  result_t   res0;
  result_t   res1;

  // output queue: entry 0 is presented on the port
  result_t   q [QDEPTH];
  result_t   q_next [QDEPTH];
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic [1:0] base;
  logic       pop;
  logic       push;

  assign cfg_ready = 1'b1;
  assign s_tready  = (cnt <= 2'd1);
  assign push      = s_tvalid && s_tready;
  assign pop       = m_tvalid && m_tready;

  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = {q[0].ir_value, q[0].angle};
  assign m_tuser  = q[0].kind;
  assign m_tlast  = q[0].last;

  tbas_step u_step (
    .st          (st),
    .cfg         (cfg),
    .req_type    (s_tuser),
    .status_code (s_tdata[6:0]),
    .st_next     (st_next),
    .n_res       (n_res),
    .res0        (res0),
    .res1        (res1)
  );

  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_next[i] = q[i];
    end
    // shift out the taken word
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_next[i] = q[i+1];
      end
    end
    base     = cnt - {1'b0, pop};
    cnt_next = base;
    if (push) begin
      for (int i = 0; i < QDEPTH; i++) begin
        if (n_res != 2'd0 && i == int'(base)) begin
          q_next[i] = res0;
        end
        if (n_res == 2'd2 && i == int'(base) + 1) begin
          q_next[i] = res1;
        end
      end
      cnt_next = base + n_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ir_first        <= 16'd1024;
      cfg.ir_last         <= 16'd4096;
      cfg.ir_increment    <= 16'd512;
      cfg.angle_tolerance <= 16'd77;
      st.running          <= 1'b0;
      st.stage            <= STAGE_PROBE0;
      st.outcome          <= OUTC_NONE;
      st.first_tripped    <= 1'b0;
      st.start_angle      <= '0;
      st.end_angle        <= ANGLE_180;
      st.probe_angle      <= '0;
      st.ir_now           <= '0;
      cnt                 <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_IR_FIRST:  cfg.ir_first        <= cfg_data;
          REG_IR_LAST:   cfg.ir_last         <= cfg_data;
          REG_IR_INCR:   cfg.ir_increment    <= cfg_data;
          REG_ANGLE_TOL: cfg.angle_tolerance <= cfg_data;
          default: begin
          end
        endcase
      end
      if (push) begin
        st <= st_next;
      end
      cnt <= cnt_next;
    end
  end

  // queue payload carries no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

endmodule

/* design/tbas_checker.sv */
// ----------------------------------------------------------------------------
// tbas_checker - port-level checks for the trip boundary angle search core
// Watches the result stream over time; bound to the top level below.
// ----------------------------------------------------------------------------
module tbas_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);
  import tbas_pkg::*;

  // stalled word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("result word changed while stalled");

  // a boundary word is never the last of its event
  a_boundary_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_BOUNDARY |-> !m_tlast)
    else $error("boundary word marked last");

  // the word after a boundary is already queued
  a_boundary_follow: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser == KIND_BOUNDARY |=> m_tvalid && m_tlast)
    else $error("word after boundary missing");

  // finish and stop carry angle zero
  a_end_angle_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_FINISHED || m_tuser == KIND_STOPPED)
      |-> m_tdata[15:0] == 16'd0 && m_tlast)
    else $error("finish or stop word with nonzero angle");

endmodule

bind trip_boundary_angle_search_core tbas_checker u_tbas_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

/* test/tb_trip_boundary_angle_search_core.sv */
// ----------------------------------------------------------------------------
// tb_trip_boundary_angle_search_core - self-checking bench for the trip
// boundary angle search sequencer
// Drives start, stop and status events into the core. A local copy of the
// sequencer predicts each result word, and the words that come out are
// checked field by field in order. The stimulus covers register extremes,
// searches against a simulated relay threshold, random noise events, and
// idling and stalls on both streams.
// ----------------------------------------------------------------------------
module tb_trip_boundary_angle_search_core;
  import tbas_pkg::*;

  localparam int TIMEOUT_CYCLES  = 2000000;
  localparam int SETTLE_CYCLES   = 4;     // event decode plus queue output
  localparam int SINK_HOLD_LEN   = 300;   // long receiver hold-off
  localparam int SEARCH_BUDGET   = 60;    // events before a search is stopped

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;     // [6:0] status_code, [7] zero
  logic [1:0]  s_tuser = '0;     // [1:0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // [15:0] angle, [31:16] ir_value
  logic [1:0]  m_tuser;          // [1:0] out_kind
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // sequencer copy and its registers
  cfg_t        cfg_model;
  state_t      srch;
  logic [15:0] relay_angle;      // angle the relay is currently set to
  result_t     pending_words[$];

  int error_count = 0;
  int events_sent = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  bit sink_hold_req = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  trip_boundary_angle_search_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Sequencer prediction
  // --------------------------------------------------------------------------
  function automatic void push_word(logic [1:0] kind, logic [15:0] ang, logic lst);
    result_t w;
    w.kind     = kind;
    w.angle    = ang;
    w.ir_value = srch.ir_now;
    w.last     = lst;
    pending_words.push_back(w);
    if (kind == KIND_PROBE) relay_angle = ang;
  endfunction

  function automatic logic [15:0] midpoint(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16:1];
  endfunction

  function automatic void restart_search();
    srch.first_tripped = 1'b0;
    srch.start_angle   = '0;
    srch.end_angle     = ANGLE_180;
    srch.probe_angle   = '0;
    srch.stage         = STAGE_PROBE0;
  endfunction

  // next current step, or the finish word once ir_last is reached
  function automatic void step_current();
    logic [16:0] sum;
    if (srch.ir_now < cfg_model.ir_last) begin
      sum = {1'b0, srch.ir_now} + {1'b0, cfg_model.ir_increment};
      srch.ir_now = sum[16] ? 16'hFFFF : sum[15:0];
      restart_search();
      push_word(KIND_PROBE, '0, 1'b1);
    end else begin
      srch.running = 1'b0;
      push_word(KIND_FINISHED, '0, 1'b1);
    end
  endfunction

  function automatic void predict_sequencer(logic [1:0] req, logic [6:0] code);
    logic        tripped;
    logic [15:0] width;
    if (req == REQ_START) begin
      if (srch.running) return;
      srch.running = 1'b1;
      srch.ir_now  = cfg_model.ir_first;
      restart_search();
      push_word(KIND_PROBE, '0, 1'b1);
      return;
    end
    if (req == REQ_STOP) begin
      if (!srch.running) return;
      srch.running = 1'b0;
      push_word(KIND_STOPPED, '0, 1'b1);
      return;
    end
    if (req != REQ_STATUS || !srch.running) return;
    if (code == CODE_NOT_TRIPPED) begin
      srch.outcome = OUTC_NOT_TRIPPED;
      return;
    end
    if (code == CODE_TRIPPED) begin
      srch.outcome = OUTC_TRIPPED;
      return;
    end
    // sequence end acts on the last outcome seen, which start never clears
    if (code != CODE_SEQ_END || srch.outcome == OUTC_NONE) return;
    tripped = (srch.outcome == OUTC_TRIPPED);
    case (srch.stage)
      STAGE_PROBE0: begin
        srch.stage = STAGE_PROBE180;
        srch.first_tripped = tripped;
        push_word(KIND_PROBE, srch.end_angle, 1'b1);
      end
      STAGE_PROBE180: begin
        if (!tripped && !srch.first_tripped) begin
          step_current();
        end else begin
          srch.stage = STAGE_BISECT;
          srch.probe_angle = midpoint(srch.start_angle, srch.end_angle);
          if (!tripped) begin
            // not tripped at 180: search runs from 180 down to 0
            srch.end_angle   = '0;
            srch.start_angle = ANGLE_180;
          end
          push_word(KIND_PROBE, srch.probe_angle, 1'b1);
        end
      end
      STAGE_BISECT: begin
        width = (srch.start_angle >= srch.end_angle) ?
                srch.start_angle - srch.end_angle : srch.end_angle - srch.start_angle;
        if (width <= cfg_model.angle_tolerance) begin
          push_word(KIND_BOUNDARY, srch.probe_angle, 1'b0);
          step_current();
        end else begin
          if (tripped) srch.end_angle = srch.probe_angle;
          else         srch.start_angle = srch.probe_angle;
          srch.probe_angle = midpoint(srch.start_angle, srch.end_angle);
          push_word(KIND_PROBE, srch.probe_angle, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // valid is only lowered in a gap or when settling, so back-to-back words
  // keep it high without a second assignment in one step
  task automatic send_event(input logic [1:0] req, input logic [6:0] code);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {1'b0, code};
    do @(posedge clk); while (!s_tready);
    predict_sequencer(req, code);
    events_sent++;
  endtask

  // wait until every predicted word is out and the core has gone quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IR_FIRST:  cfg_model.ir_first        = val;
      REG_IR_LAST:   cfg_model.ir_last         = val;
      REG_IR_INCR:   cfg_model.ir_increment    = val;
      REG_ANGLE_TOL: cfg_model.angle_tolerance = val;
      default: ;
    endcase
  endtask

  // only called with the core idle
  task automatic set_config(input logic [15:0] first, input logic [15:0] last_ir,
                            input logic [15:0] incr, input logic [15:0] tol);
    write_reg(REG_IR_FIRST, first);
    write_reg(REG_IR_LAST, last_ir);
    write_reg(REG_IR_INCR, incr);
    write_reg(REG_ANGLE_TOL, tol);
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_random_config();
    logic [15:0] first, incr, tol;
    int          last_ir;
    first = 16'($urandom_range(65535));
    incr  = ($urandom_range(3) == 0) ? 16'($urandom_range(1, 65535))
                                     : 16'($urandom_range(1, 2000));
    last_ir = int'(first) + int'(incr) * int'($urandom_range(0, 3));
    if (last_ir > 65535) last_ir = 65535;
    case ($urandom_range(9))
      0:       tol = 16'd0;
      1:       tol = ANGLE_180;
      default: tol = 16'($urandom_range(40, 4000));
    endcase
    if ($urandom_range(7) == 0) incr = 16'hFFFF;
    set_config(first, 16'(last_ir), incr, tol);
  endtask

  // One test run: start, then outcome/sequence-end pairs against a relay
  // that trips at or below a threshold angle, with some noise and broken pairs.
  task automatic drive_search(input int budget, input bit random_relay);
    int          n;
    logic [15:0] threshold;
    logic        tripped;
    threshold = 16'($urandom_range(46080));
    send_event(REQ_START, 7'($urandom_range(127)));
    n = 1;
    while (srch.running && n < budget) begin
      if ($urandom_range(99) < 8) begin
        send_event(2'($urandom_range(3)), 7'($urandom_range(127)));
        n++;
      end else begin
        if (random_relay) tripped = 1'($urandom_range(1));
        else tripped = (relay_angle <= threshold) ^ ($urandom_range(99) < 5);
        if ($urandom_range(99) >= 4)
          send_event(REQ_STATUS, tripped ? CODE_TRIPPED : CODE_NOT_TRIPPED);
        send_event(REQ_STATUS, CODE_SEQ_END);
        n += 2;
      end
    end
    if (srch.running) send_event(REQ_STOP, 7'($urandom_range(127)));
  endtask

  // --------------------------------------------------------------------------
  // Output side: stalls, a long hold-off on request, and the word check
  // --------------------------------------------------------------------------
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (SINK_HOLD_LEN) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin : word_check
    result_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: kind %0d angle %0d ir %0d last %0d",
               m_tuser, m_tdata[15:0], m_tdata[31:16], m_tlast);
        error_count++;
      end else begin
        w = pending_words.pop_front();
        if (m_tuser != w.kind) begin
          $error("out_kind: expected %0d, got %0d", w.kind, m_tuser);
          error_count++;
        end
        if (m_tdata[15:0] != w.angle) begin
          $error("angle: expected %0d, got %0d", w.angle, m_tdata[15:0]);
          error_count++;
        end
        if (m_tdata[31:16] != w.ir_value) begin
          $error("ir_value: expected %0d, got %0d", w.ir_value, m_tdata[31:16]);
          error_count++;
        end
        if (m_tlast != w.last) begin
          $error("last: expected %0d, got %0d", w.last, m_tlast);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // ignored events, the stale-outcome cases, the 180 swap, stop and restart
  task automatic test_directed_sequence();
    send_event(REQ_STATUS, CODE_NOT_TRIPPED);   // idle: ignored
    send_event(REQ_STOP, 7'd0);                 // idle: ignored
    send_event(2'd3, 7'h7F);                    // unused request kind
    send_event(REQ_START, 7'd0);
    send_event(REQ_START, 7'h7F);               // already running
    send_event(REQ_STATUS, CODE_SEQ_END);       // no outcome seen yet
    send_event(REQ_STATUS, 7'd0);
    send_event(REQ_STATUS, 7'h7F);
    send_event(REQ_STATUS, CODE_TRIPPED);
    send_event(REQ_STATUS, CODE_SEQ_END);       // probe 180
    send_event(REQ_STATUS, CODE_NOT_TRIPPED);
    send_event(REQ_STATUS, CODE_SEQ_END);       // swapped bisection
    send_event(REQ_STATUS, CODE_TRIPPED);
    send_event(REQ_STATUS, CODE_SEQ_END);
    send_event(REQ_STATUS, CODE_NOT_TRIPPED);
    send_event(REQ_STATUS, CODE_SEQ_END);
    send_event(REQ_STOP, 7'h7F);
    send_event(2'd3, 7'd0);
    send_event(REQ_START, 7'h55);
    send_event(REQ_STATUS, CODE_SEQ_END);       // outcome kept across start
    send_event(REQ_STATUS, CODE_SEQ_END);       // never tripped: next current
    send_event(REQ_STATUS, 7'h2A);
    send_event(REQ_STOP, 7'd0);
    settle();
  endtask

  task automatic test_register_extremes();
    // widest tolerance, top current, nothing left to step: boundary then finish
    set_config(16'hFFFF, 16'd0, 16'd1, ANGLE_180);
    send_event(REQ_START, 7'd0);
    send_event(REQ_STATUS, CODE_TRIPPED);
    send_event(REQ_STATUS, CODE_SEQ_END);
    send_event(REQ_STATUS, CODE_SEQ_END);
    send_event(REQ_STATUS, CODE_SEQ_END);
    send_event(REQ_STATUS, CODE_SEQ_END);       // after finish: ignored
    settle();
    // zero start, a full step reaches the top current, then finish
    set_config(16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
    send_event(REQ_START, 7'd0);
    send_event(REQ_STATUS, CODE_NOT_TRIPPED);
    repeat (4) send_event(REQ_STATUS, CODE_SEQ_END);
    settle();
    // zero tolerance, unit step
    set_config(16'd100, 16'd102, 16'd1, 16'd0);
    drive_search(SEARCH_BUDGET, 1'b0);
    settle();
  endtask

  task automatic test_random_searches(input int src_pct, input int sink_pct,
                                      input int goal);
    int stop_at;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    stop_at = events_sent + goal;
    while (events_sent < stop_at) begin
      pick_random_config();
      repeat ($urandom_range(1, 3)) drive_search(SEARCH_BUDGET, $urandom_range(3) == 0);
      settle();
    end
  endtask

  // receiver holds off while the sender keeps pushing, so the input stalls;
  // then the sender waits for every word before going on
  task automatic test_output_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    set_config(16'd1024, 16'd4096, 16'd512, 16'd77);
    sink_hold_req = 1'b1;
    drive_search(SEARCH_BUDGET, 1'b0);
    settle();
    drive_search(SEARCH_BUDGET, 1'b0);
    settle();
  endtask

  initial begin : main
    cfg_model.ir_first        = 16'd1024;
    cfg_model.ir_last         = 16'd4096;
    cfg_model.ir_increment    = 16'd512;
    cfg_model.angle_tolerance = 16'd77;
    srch.running       = 1'b0;
    srch.stage         = STAGE_PROBE0;
    srch.outcome       = OUTC_NONE;
    srch.first_tripped = 1'b0;
    srch.start_angle   = '0;
    srch.end_angle     = ANGLE_180;
    srch.probe_angle   = '0;
    srch.ir_now        = '0;
    relay_angle        = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    src_idle_pct   = 10;
    sink_stall_pct = 87;
    test_directed_sequence();
    test_register_extremes();
    test_random_searches(10, 87, 180);
    test_random_searches(87, 10, 180);
    test_random_searches(0, 0, 180);
    test_output_backpressure();
    settle();
    if (error_count == 0) begin
      $display("trip_boundary_angle_search_core: match");
    end else begin
      $display("trip_boundary_angle_search_core: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #(20 * TIMEOUT_CYCLES);
    $display("trip_boundary_angle_search_core: mismatch");
    $finish;
  end

endmodule
